// File: rtl/mclpi_pkg.sv
// shared types, constants and the control program of the motor current limiter
`timescale 1ns / 1ps

package mclpi_pkg;

	localparam int NUM_MOTORS = 2;
	localparam int CFG_AW     = 5;
	localparam int PC_W       = 4;

	// configuration register indexes (byte address is 4 * index)
	localparam logic [2:0] REG_GAIN_P       = 3'd0;
	localparam logic [2:0] REG_GAIN_I       = 3'd1;
	localparam logic [2:0] REG_SAMPLE_TIME  = 3'd2;
	localparam logic [2:0] REG_MAX_CURRENT  = 3'd3;
	localparam logic [2:0] REG_TRIP_CURRENT = 3'd4;
	localparam logic [2:0] REG_MAX_STEP     = 3'd5;

	localparam logic [23:0] GAIN_P_RST       = 24'd6554;
	localparam logic [23:0] GAIN_I_RST       = 24'd262144;
	localparam logic [23:0] SAMPLE_TIME_RST  = 24'd167772;
	localparam logic [15:0] MAX_CURRENT_RST  = 16'd1638;
	localparam logic [15:0] TRIP_CURRENT_RST = 16'd2458;
	localparam logic [14:0] MAX_STEP_RST     = 15'd8192;

	typedef struct packed {
		logic               motor_index;
		logic signed [15:0] set_ratio;
		logic        [15:0] current;
	} cmd_t;

	typedef struct packed {
		logic               motor_out;
		logic signed [15:0] drive_ratio;
		logic               tripped;
	} rsp_t;

	// multiplier operand routing and destination
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_GI,
		MUL_LO,
		MUL_HI,
		MUL_GP
	} mul_sel_t;

	// add / clamp unit operation
	typedef enum logic [2:0] {
		ALU_NONE,
		ALU_PREP,
		ALU_DI,
		ALU_INTEG,
		ALU_RC
	} alu_sel_t;

	// result writeback
	typedef enum logic [1:0] {
		RES_NONE,
		RES_DRIVE,
		RES_TRIP
	} res_sel_t;

	typedef struct packed {
		mul_sel_t         mul;
		alu_sel_t         alu;
		logic             jump;
		logic [PC_W-1:0]  target;
		logic             last;
		res_sel_t         res;
	} ctrl_word_t;

	localparam ctrl_word_t CTRL_NOP = '{
		mul:    MUL_NONE,
		alu:    ALU_NONE,
		jump:   1'b0,
		target: '0,
		last:   1'b0,
		res:    RES_NONE
	};

	// program steps
	localparam logic [PC_W-1:0] ST_PREP  = 4'd0;
	localparam logic [PC_W-1:0] ST_GI    = 4'd1;
	localparam logic [PC_W-1:0] ST_LO    = 4'd2;
	localparam logic [PC_W-1:0] ST_HI    = 4'd3;
	localparam logic [PC_W-1:0] ST_GP    = 4'd4;
	localparam logic [PC_W-1:0] ST_INTEG = 4'd5;
	localparam logic [PC_W-1:0] ST_RC    = 4'd6;
	localparam logic [PC_W-1:0] ST_WB    = 4'd7;
	localparam logic [PC_W-1:0] ST_TRIP  = 4'd8;

	function automatic ctrl_word_t mclpi_ucode(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		w = CTRL_NOP;
		case (pc)
			ST_PREP: begin
				w.alu    = ALU_PREP;
				w.jump   = 1'b1;
				w.target = ST_TRIP;
			end
			ST_GI: begin
				w.mul = MUL_GI;
			end
			ST_LO: begin
				w.mul = MUL_LO;
			end
			ST_HI: begin
				w.mul = MUL_HI;
			end
			ST_GP: begin
				w.mul = MUL_GP;
				w.alu = ALU_DI;
			end
			ST_INTEG: begin
				w.alu = ALU_INTEG;
			end
			ST_RC: begin
				w.alu = ALU_RC;
			end
			ST_WB: begin
				w.res  = RES_DRIVE;
				w.last = 1'b1;
			end
			ST_TRIP: begin
				w.res  = RES_TRIP;
				w.last = 1'b1;
			end
			default: begin
				w.last = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

// File: rtl/mclpi_seq.sv
// step counter and control program sequencer for the current limiter datapath
`timescale 1ns / 1ps

module mclpi_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  hold,
	input  logic                  cond,
	output mclpi_pkg::ctrl_word_t ctl,
	output logic                  busy
);
	import mclpi_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic            run_q;
	ctrl_word_t      word;
	logic            issue;

	assign word  = mclpi_ucode(pc_q);
	// the final step waits while the result slot is still occupied
	assign issue = run_q && !(word.last && hold);
	assign busy  = run_q;

	always_comb begin
		ctl = word;
		if (!issue) begin
			ctl = CTRL_NOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			run_q <= 1'b0;
		end else if (start) begin
			pc_q  <= ST_PREP;
			run_q <= 1'b1;
		end else if (issue) begin
			if (word.last) begin
				run_q <= 1'b0;
			end else if (word.jump && cond) begin
				pc_q <= word.target;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

endmodule

// File: rtl/motor_current_limit_pi_core.sv
// top level of the per-motor current limiter with slew limit and pi magnitude cap
`timescale 1ns / 1ps

// usage:
// - cmd channel (cmd_valid / cmd_stall / cmd) brings one tick item: motor index,
//   signed requested ratio (q2.14) and measured current (q4.12)
// - rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one result item per
//   tick: the motor, the signed drive ratio (q2.14) and the trip flag
// - apb port holds gain_p, gain_i, sample_time, max_current, trip_current and
//   max_step at byte addresses 0, 4, 8, 12, 16, 20; write only while idle
// - program: a normal item runs the 8-step control program and the next item
//   is taken once it has finished; an overcurrent item jumps straight to the
//   trip step and takes 2 steps
// - the program length is set by the single shared 24x24 multiplier, used
//   four times per normal item, and the add / clamp unit that follows it
// - cmd_stall is high while the program runs; a finished result sits in the
//   rsp register, so the next item is accepted while it waits
// - if rsp_stall holds the previous result, the final step of the next item
//   waits until that result is taken
// - reset clears the per-motor integrator and last drive, loads the
//   register defaults and empties the result register
module motor_current_limit_pi_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// tick items
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  mclpi_pkg::cmd_t             cmd,
	// result items
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output mclpi_pkg::rsp_t             rsp,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mclpi_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import mclpi_pkg::*;

	localparam logic signed [48:0] SAT_MAX = (49'sd1 <<< 47) - 49'sd1;
	localparam logic signed [48:0] ONE_Q28 = 49'sd1 <<< 28;
	localparam logic signed [15:0] DRIVE_MAX = 16'sd16384;

	// configuration registers
	logic [23:0] gain_p_q;
	logic [23:0] gain_i_q;
	logic [23:0] sample_time_q;
	logic [15:0] max_current_q;
	logic [15:0] trip_current_q;
	logic [14:0] max_step_q;

	// per-motor state
	logic signed [47:0] integ_q [NUM_MOTORS];
	logic signed [15:0] last_q  [NUM_MOTORS];

	// captured item
	logic               m_q;
	logic signed [15:0] req_q;
	logic        [15:0] cur_q;

	// datapath registers
	logic        [15:0] emag_q;
	logic               eneg_q;
	logic        [15:0] rmag_q;
	logic               rneg_q;
	logic        [39:0] a_q;
	logic        [47:0] t_q;
	logic        [39:0] u_q;
	logic signed [40:0] p_q;
	logic        [40:0] di_q;
	logic signed [47:0] x_q;
	logic        [28:0] rc_q;

	logic               rsp_valid_q;
	rsp_t               rsp_q;

	// sequencer
	ctrl_word_t ctl;
	logic       busy;
	logic       cmd_acc;
	logic       rsp_acc;
	logic       cfg_wr;
	logic       motor_ok;
	logic       trip_hit;

	// combinational datapath
	logic signed [16:0] err;
	logic signed [16:0] err_neg;
	logic        [15:0] emag;
	logic signed [17:0] act_x;
	logic signed [17:0] req_x;
	logic signed [17:0] step_x;
	logic signed [17:0] up_lim;
	logic signed [17:0] dn_lim;
	logic signed [17:0] r;
	logic signed [17:0] r_neg;
	logic        [23:0] mul_a;
	logic        [23:0] mul_b;
	logic        [47:0] mul_p;
	logic signed [40:0] p_mag;
	logic signed [41:0] di_s;
	logic signed [48:0] isum;
	logic signed [48:0] isat;
	logic signed [48:0] csum;
	logic signed [48:0] clim;
	logic signed [48:0] cval;
	logic signed [48:0] inext;
	logic signed [15:0] mag_s;
	logic signed [15:0] drive;

	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign rsp_acc   = rsp_valid_q && !rsp_stall;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign cmd_stall = busy;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign motor_ok = int'(m_q) < NUM_MOTORS;
	assign trip_hit = cur_q >= trip_current_q;

	mclpi_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd_acc),
		.hold   (rsp_valid_q && rsp_stall),
		.cond   (trip_hit || !motor_ok),
		.ctl    (ctl),
		.busy   (busy)
	);

	// register readback
	always_comb begin
		case (paddr[4:2])
			REG_GAIN_P:       prdata = {8'b0, gain_p_q};
			REG_GAIN_I:       prdata = {8'b0, gain_i_q};
			REG_SAMPLE_TIME:  prdata = {8'b0, sample_time_q};
			REG_MAX_CURRENT:  prdata = {16'b0, max_current_q};
			REG_TRIP_CURRENT: prdata = {16'b0, trip_current_q};
			REG_MAX_STEP:     prdata = {17'b0, max_step_q};
			default:          prdata = '0;
		endcase
	end

	// headroom error and slew limit on the request
	always_comb begin
		err     = signed'({1'b0, max_current_q}) - signed'({1'b0, cur_q});
		err_neg = -err;
		emag    = err[16] ? err_neg[15:0] : err[15:0];

		act_x  = 18'(last_q[m_q]);
		req_x  = 18'(req_q);
		step_x = signed'({3'b0, max_step_q});
		up_lim = act_x + step_x;
		dn_lim = act_x - step_x;
		if (req_x > 18'sd0 && act_x >= 18'sd0) begin
			// moving away from zero forward is capped, toward zero is free
			r = (req_x > up_lim) ? up_lim : req_x;
		end else if (req_x < 18'sd0 && act_x <= 18'sd0) begin
			r = (req_x < dn_lim) ? dn_lim : req_x;
		end else begin
			// reversal or zero request
			r = '0;
		end
		r_neg = -r;
	end

	// shared multiplier operand routing
	always_comb begin
		case (ctl.mul)
			MUL_GI: begin
				mul_a = {8'b0, emag_q};
				mul_b = gain_i_q;
			end
			MUL_LO: begin
				mul_a = a_q[23:0];
				mul_b = sample_time_q;
			end
			MUL_HI: begin
				mul_a = {8'b0, a_q[39:24]};
				mul_b = sample_time_q;
			end
			MUL_GP: begin
				mul_a = {8'b0, emag_q};
				mul_b = gain_p_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
		p_mag = signed'({1'b0, mul_p[39:0]});
	end

	// integrator update, output clamp and back-calculation
	always_comb begin
		di_s = eneg_q ? -signed'({1'b0, di_q}) : signed'({1'b0, di_q});
		isum = 49'(integ_q[m_q]) + 49'(di_s);
		if (isum > SAT_MAX) begin
			isat = SAT_MAX;
		end else if (isum < -SAT_MAX) begin
			isat = -SAT_MAX;
		end else begin
			isat = isum;
		end

		csum = 49'(p_q) + 49'(x_q);
		clim = signed'({19'b0, rmag_q, 14'b0});
		cval = csum;
		if (cval > clim) begin
			cval = clim;
		end
		if (cval > ONE_Q28) begin
			cval = ONE_Q28;
		end
		if (cval < 49'sd0) begin
			cval = '0;
		end

		inext = signed'({20'b0, rc_q}) - 49'(p_q);
		mag_s = signed'({1'b0, rc_q[28:14]});
		drive = rneg_q ? -mag_s : mag_s;
	end

	// control state, configuration and per-motor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q       <= GAIN_P_RST;
			gain_i_q       <= GAIN_I_RST;
			sample_time_q  <= SAMPLE_TIME_RST;
			max_current_q  <= MAX_CURRENT_RST;
			trip_current_q <= TRIP_CURRENT_RST;
			max_step_q     <= MAX_STEP_RST;
			rsp_valid_q    <= 1'b0;
			for (int i = 0; i < NUM_MOTORS; i++) begin
				integ_q[i] <= '0;
				last_q[i]  <= '0;
			end
		end else begin
			if (cfg_wr) begin
				case (paddr[4:2])
					REG_GAIN_P:       gain_p_q       <= pwdata[23:0];
					REG_GAIN_I:       gain_i_q       <= pwdata[23:0];
					REG_SAMPLE_TIME:  sample_time_q  <= pwdata[23:0];
					REG_MAX_CURRENT:  max_current_q  <= pwdata[15:0];
					REG_TRIP_CURRENT: trip_current_q <= pwdata[15:0];
					REG_MAX_STEP:     max_step_q     <= pwdata[14:0];
					default: ;
				endcase
			end

			case (ctl.res)
				RES_DRIVE: begin
					integ_q[m_q] <= inext[47:0];
					last_q[m_q]  <= drive;
				end
				RES_TRIP: begin
					// integrator is kept across a trip
					if (motor_ok) begin
						last_q[m_q] <= '0;
					end
				end
				default: ;
			endcase

			if (ctl.res != RES_NONE) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_acc) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			m_q   <= cmd.motor_index;
			req_q <= cmd.set_ratio;
			cur_q <= cmd.current;
		end

		case (ctl.alu)
			ALU_PREP: begin
				emag_q <= emag;
				eneg_q <= err[16];
				rmag_q <= r[17] ? r_neg[15:0] : r[15:0];
				rneg_q <= r[17];
			end
			ALU_DI: begin
				// hi partial product already sits 24 bits up
				di_q <= 41'(u_q) + 41'(t_q[47:24]);
			end
			ALU_INTEG: begin
				x_q <= isat[47:0];
			end
			ALU_RC: begin
				rc_q <= cval[28:0];
			end
			default: ;
		endcase

		case (ctl.mul)
			MUL_GI: a_q <= mul_p[39:0];
			MUL_LO: t_q <= mul_p;
			MUL_HI: u_q <= mul_p[39:0];
			MUL_GP: p_q <= eneg_q ? -p_mag : p_mag;
			default: ;
		endcase

		case (ctl.res)
			RES_DRIVE: begin
				rsp_q.motor_out   <= m_q;
				rsp_q.drive_ratio <= drive;
				rsp_q.tripped     <= 1'b0;
			end
			RES_TRIP: begin
				rsp_q.motor_out   <= m_q;
				rsp_q.drive_ratio <= '0;
				rsp_q.tripped     <= motor_ok;
			end
			default: ;
		endcase
	end

	// an accepted item keeps the sequencer busy on the next cycle
	a_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> cmd_stall)
		else $error("sequencer not busy after item accept");

	// a tripped result never carries drive
	a_trip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.tripped) |-> (rsp.drive_ratio == 16'sd0))
		else $error("tripped result with nonzero drive");

	// drive magnitude never exceeds full scale
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.drive_ratio <= DRIVE_MAX && rsp.drive_ratio >= -DRIVE_MAX))
		else $error("drive ratio out of range");

	// a fresh result appears only as the program finishes
	a_rsp_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !busy)
		else $error("result raised while program still running");

	// the clamped control value stays within 0..1.0
	a_rc_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ctl.alu == ALU_RC) |-> (rc_q <= 29'(ONE_Q28)))
		else $error("clamped value above unity");

endmodule
